// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rbd_pkg.sv =====
// shared types, constants and helpers for the rgba8 box downscaler
// no dependencies
package rbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CHAN_W     = 8;
  localparam int NCHAN      = 4;
  localparam int SUM_W      = 32;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int QUO_W      = 8;
  localparam int QDEPTH     = 2;
  localparam int DIV_STEPS  = DIM_W;

  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {SU_LOAD, SU_RUN, SU_FIN, SU_IDLE} setup_state_t;
  typedef enum logic {F_IDLE, F_ACC} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} back_state_t;

  typedef struct packed {
    dim_t sw;
    dim_t sh;
    dim_t dw;
    dim_t dh;
    dim_t qw;
    dim_t rw;
    dim_t qh;
    dim_t rh;
    logic busy;
    logic restart;
  } geom_t;

  typedef struct packed {
    logic [NCHAN-1:0][SUM_W-1:0] sums;
    logic [AREA_W-1:0]           area;
    logic                        last;
  } job_t;

  typedef struct packed {
    logic [DIM_W:0] rem;
    dim_t           quo;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(div_t cur, dim_t den);
    logic [DIM_W:0] trial;
    div_t           nxt;
    trial = {cur.rem[DIM_W-1:0], cur.quo[DIM_W-1]};
    if (trial >= {1'b0, den}) begin
      nxt.rem = trial - {1'b0, den};
      nxt.quo = {cur.quo[DIM_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial;
      nxt.quo = {cur.quo[DIM_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic dim_t clamp_dim(dim_t v, dim_t hi);
    dim_t r;
    if (v == '0) r = dim_t'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// ===== hw/rtl/rbd_if.sv =====
// stream interfaces: source pixel channel and averaged pixel channel
// no dependencies
interface rbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rbd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       last_pixel;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  output ready);
endinterface

// ===== hw/rtl/rbd_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rbd_setup.sv =====
// size registers and the two size dividers (sw/dw and sh/dh)
// depends on rbd_pkg
module rbd_setup import rbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output geom_t            geom
);
  dim_t         src_w, src_h, dst_w, dst_h;
  dim_t         sw, sh, dw, dh;
  div_t         divw, divh;
  logic [$clog2(DIV_STEPS)-1:0] cnt;
  setup_state_t state, state_next;

  assign sw = clamp_dim(src_w, dim_t'(MAX_WIDTH));
  assign sh = clamp_dim(src_h, dim_t'(MAX_HEIGHT));
  assign dw = clamp_dim(dst_w, sw);
  assign dh = clamp_dim(dst_h, sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= dim_t'(1);
      src_h <= dim_t'(1);
      dst_w <= dim_t'(1);
      dst_h <= dim_t'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:  src_w <= cfg_data;
        REG_SRC_HEIGHT: src_h <= cfg_data;
        REG_DST_WIDTH:  dst_w <= cfg_data;
        REG_DST_HEIGHT: dst_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SU_LOAD: state_next = SU_RUN;
      SU_RUN:  if (cnt == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) state_next = SU_FIN;
      SU_FIN:  state_next = SU_IDLE;
      SU_IDLE: state_next = SU_IDLE;
      default: state_next = SU_LOAD;
    endcase
    if (cfg_we) state_next = SU_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SU_LOAD;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == SU_LOAD) begin
      divw <= '{rem: '0, quo: sw};
      divh <= '{rem: '0, quo: sh};
      cnt  <= '0;
    end else if (state == SU_RUN) begin
      divw <= div_step(divw, dw);
      divh <= div_step(divh, dh);
      cnt  <= cnt + 1'b1;
    end
  end

  always_comb begin
    geom.sw      = sw;
    geom.sh      = sh;
    geom.dw      = dw;
    geom.dh      = dh;
    geom.qw      = divw.quo;
    geom.rw      = divw.rem[DIM_W-1:0];
    geom.qh      = divh.quo;
    geom.rh      = divh.rem[DIM_W-1:0];
    geom.busy    = (state != SU_IDLE);
    geom.restart = (state == SU_FIN);
  end
endmodule

// ===== hw/rtl/rbd_fifo.sv =====
// short job queue between the accumulating front and the dividing back
// depends on rbd_pkg
module rbd_fifo import rbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);
  localparam int PTR_W = $clog2(QDEPTH);

  job_t             mem [QDEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W:0]   cnt;

  assign full  = (cnt == (PTR_W+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/rbd_front.sv =====
// front: takes pixels, tracks windows and bands, accumulates the line store
// depends on rbd_pkg, rbd_if, rbd_ram
module rbd_front import rbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rbd_pix_if.sink    pix,
  input  geom_t      geom,
  input  logic       full,
  output logic       push,
  output job_t       job
);
  front_state_t state, state_next;

  logic [COL_W-1:0] sc, tc, sc_next, tc_next;
  logic [ROW_W-1:0] sr, tr, sr_next, tr_next;
  dim_t cs, ce, cr, bs, be, br;
  dim_t cs_next, ce_next, cr_next, bs_next, be_next, br_next;
  logic [NCHAN-1:0][CHAN_W-1:0] px;
  logic [NCHAN-1:0][SUM_W-1:0]  rdata, sums;
  logic acc, fresh, win_end;
  logic [DIM_W:0] ct, rt;
  logic col_carry, row_carry;
  dim_t ce_step, cr_step, be_step, br_step, sc1, sr1;

  rbd_ram #(.WIDTH(NCHAN*SUM_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk  (clk),
    .we   (acc),
    .waddr(tc),
    .wdata(sums),
    .raddr(tc),
    .rdata(rdata)
  );

  // next-state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (pix.valid && pix.ready) state_next = F_ACC;
      F_ACC:   state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pix.ready = (state == F_IDLE) && !geom.busy && !full;
    acc       = (state == F_ACC);
    push      = acc && win_end;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      px[0] <= pix.in_red;
      px[1] <= pix.in_green;
      px[2] <= pix.in_blue;
      px[3] <= pix.in_alpha;
    end
  end

  // first pixel of a window starts from zero, the stored entry is stale
  assign fresh   = (DIM_W'(sr) == bs) && (DIM_W'(sc) == cs);
  assign sc1     = DIM_W'(sc) + 1'b1;
  assign sr1     = DIM_W'(sr) + 1'b1;
  assign win_end = (sr1 == be) && (sc1 == ce);

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      sums[i] = (fresh ? '0 : rdata[i]) + SUM_W'(px[i]);
    end
  end

  assign job.sums = sums;
  assign job.area = AREA_W'(be - bs) * AREA_W'(ce - cs);
  assign job.last = (DIM_W'(tc) + 1'b1 == geom.dw) && (DIM_W'(tr) + 1'b1 == geom.dh);

  // incremental window edges: end += q, plus one when the remainder wraps
  always_comb begin
    ct        = {1'b0, cr} + {1'b0, geom.rw};
    col_carry = ct >= {1'b0, geom.dw};
    cr_step   = col_carry ? DIM_W'(ct - {1'b0, geom.dw}) : DIM_W'(ct);
    ce_step   = ce + geom.qw + DIM_W'(col_carry);
    rt        = {1'b0, br} + {1'b0, geom.rh};
    row_carry = rt >= {1'b0, geom.dh};
    br_step   = row_carry ? DIM_W'(rt - {1'b0, geom.dh}) : DIM_W'(rt);
    be_step   = be + geom.qh + DIM_W'(row_carry);
  end

  always_comb begin
    sc_next = sc; tc_next = tc; sr_next = sr; tr_next = tr;
    cs_next = cs; ce_next = ce; cr_next = cr;
    bs_next = bs; be_next = be; br_next = br;
    if (geom.restart) begin
      sc_next = '0; tc_next = '0; sr_next = '0; tr_next = '0;
      cs_next = '0; ce_next = geom.qw; cr_next = geom.rw;
      bs_next = '0; be_next = geom.qh; br_next = geom.rh;
    end else if (acc) begin
      sc_next = COL_W'(sc1);
      if (sc1 >= ce && DIM_W'(tc) + 1'b1 < geom.dw) begin
        tc_next = tc + 1'b1;
        cs_next = ce;
        ce_next = ce_step;
        cr_next = cr_step;
      end
      if (sc1 >= geom.sw) begin
        sc_next = '0;
        tc_next = '0;
        cs_next = '0;
        ce_next = geom.qw;
        cr_next = geom.rw;
        sr_next = ROW_W'(sr1);
        if (sr1 >= geom.sh) begin
          sr_next = '0;
          tr_next = '0;
          bs_next = '0;
          be_next = geom.qh;
          br_next = geom.rh;
        end else if (sr1 >= be && DIM_W'(tr) + 1'b1 < geom.dh) begin
          tr_next = tr + 1'b1;
          bs_next = be;
          be_next = be_step;
          br_next = br_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0; tc <= '0; sr <= '0; tr <= '0;
      cs <= '0; ce <= dim_t'(1); cr <= '0;
      bs <= '0; be <= dim_t'(1); br <= '0;
    end else begin
      sc <= sc_next; tc <= tc_next; sr <= sr_next; tr <= tr_next;
      cs <= cs_next; ce <= ce_next; cr <= cr_next;
      bs <= bs_next; be <= be_next; br <= br_next;
    end
  end
endmodule

// ===== hw/rtl/rbd_back.sv =====
// back: divides the four window sums by the area, one quotient bit a cycle
// depends on rbd_pkg, rbd_if
module rbd_back import rbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       din,
  input  logic       empty,
  output logic       pop,
  rbd_res_if.source  res
);
  back_state_t state, state_next;

  logic [NCHAN-1:0][SUM_W-1:0] rem;
  logic [NCHAN-1:0][QUO_W-1:0] quo;
  logic [SUM_W:0]              dvs;
  logic                        last;
  logic [$clog2(QUO_W)-1:0]    cnt;
  logic [NCHAN-1:0]            ge;

  // next-state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!empty) state_next = B_DIV;
      B_DIV:   if (cnt == ($clog2(QUO_W))'(QUO_W - 1)) state_next = B_OUT;
      B_OUT:   if (res.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = (state == B_IDLE) && !empty;
    res.valid = (state == B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    for (int i = 0; i < NCHAN; i++) ge[i] = {1'b0, rem[i]} >= dvs;
  end

  // average never exceeds 255, so eight quotient bits cover it
  always_ff @(posedge clk) begin
    if (pop) begin
      rem  <= din.sums;
      dvs  <= (SUM_W+1)'(din.area) << (QUO_W - 1);
      last <= din.last;
      cnt  <= '0;
    end else if (state == B_DIV) begin
      for (int i = 0; i < NCHAN; i++) begin
        if (ge[i]) rem[i] <= rem[i] - dvs[SUM_W-1:0];
        quo[i] <= {quo[i][QUO_W-2:0], ge[i]};
      end
      dvs <= dvs >> 1;
      cnt <= cnt + 1'b1;
    end
  end

  assign res.out_red    = quo[0];
  assign res.out_green  = quo[1];
  assign res.out_blue   = quo[2];
  assign res.out_alpha  = quo[3];
  assign res.last_pixel = last;
endmodule

// ===== hw/rtl/rgba8_box_downscale_top.sv =====
// channel   dir  payload                                       handshake
// cfg       in   cfg_index[1:0], cfg_data[12:0]                cfg_we
// pix       in   in_red, in_green, in_blue, in_alpha           valid/ready
// res       out  out_red, out_green, out_blue, out_alpha, last valid/ready
//
// a pixel in the front: line store read, then add and write back
// each averaged pixel in the back: load, divide, then output until res.ready
// a two-entry queue sits between them; full queue stalls pix.ready
// after reset or any register write, pix.ready stays low during size division
// line store needs no clearing: the first pixel of every window overwrites it
// rst is synchronous, active high
module rgba8_box_downscale_top import rbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  rbd_pix_if.sink          pix,
  rbd_res_if.source        res
);
  geom_t geom;
  job_t  fjob, bjob;
  logic  push, pop, full, empty;

  rbd_setup u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom)
  );

  rbd_front u_front (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .geom(geom),
    .full(full),
    .push(push),
    .job (fjob)
  );

  rbd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (fjob),
    .full (full),
    .pop  (pop),
    .dout (bjob),
    .empty(empty)
  );

  rbd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .din  (bjob),
    .empty(empty),
    .pop  (pop),
    .res  (res)
  );
endmodule

// ===== hw/rtl/rbd_checker.sv =====
// port-level checks for the box downscaler, bound to the top level
// depends on assert_macros.svh and rgba8_box_downscale_top
`include "assert_macros.svh"

module rbd_checker (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready
);
  `CHK_NXT(a_res_hold, res_valid && !res_ready, res_valid)
  `CHK_IMP(a_busy_after_reset, $fell(rst), !pix_ready)
  `CHK_NXT(a_busy_after_cfg, cfg_we, !pix_ready)
  `CHK_NXT(a_two_cycle_pixel, pix_valid && pix_ready, !pix_ready)
endmodule

bind rgba8_box_downscale_top rbd_checker u_rbd_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .pix_valid(pix.valid),
  .pix_ready(pix.ready),
  .res_valid(res.valid),
  .res_ready(res.ready)
);
